// ----- src/gdo_pkg.sv -----
// Shared constants, types and calendar helper functions for the date offset block.
package gdo_pkg;

  localparam int OFFSET_BITS = 21;
  localparam int DAYS_W = ((OFFSET_BITS > 10) ? OFFSET_BITS : 10) + 2;

  localparam logic [13:0] MAX_YEAR = 14'd9999;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [13:0]            new_year;
    logic [3:0]             new_month;
    logic [4:0]             new_day;
    logic [OFFSET_BITS-1:0] day_offset;
  } item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  status;
  } result_t;

  // The year is held as century and year within century.
  function automatic logic is_leap(logic [6:0] cent, logic [6:0] yic);
    return (yic[1:0] == 2'b00) && ((yic != 7'd0) || (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [8:0] days_in_year(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] days_in_month(logic leap, logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2: d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- src/gregorian_date_offset.sv -----
// Top level of the Gregorian date offset block: handshakes and output register.
//
// The block holds one Gregorian date, 2000-01-01 after reset. Each input word
// carries a command: set (command 0) checks new_year, new_month and new_day
// and stores the date if it is valid, or advance (command 1) adds the signed
// day_offset to the stored date. Every command returns exactly one result
// word with the stored date after the command and a status: 0 ok, 1 invalid
// date rejected, 2 year out of range, in which case the date is kept.
// Both channels use valid and ready; a word moves when both are high.
// The block takes one command at a time and holds in_ready low while busy.
// A set passes through the split and check states before its result is ready.
// An advance first adds the days before the stored date in its year, then
// rolls years back or forward and splits the rest into months, all on the one
// shared day-count adder that steps one year or one month per cycle.
// The result sits in an output register; when the receiver stalls, a
// following result waits in the sequencer and no new command is taken.
// A synchronous reset on rst restores the date and drops any pending word.
module gregorian_date_offset (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [13:0]                     new_year,
  input  logic [3:0]                      new_month,
  input  logic [4:0]                      new_day,
  input  logic [gdo_pkg::OFFSET_BITS-1:0] day_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [13:0]                     cur_year,
  output logic [3:0]                      cur_month,
  output logic [4:0]                      cur_day,
  output logic [1:0]                      status
);
  import gdo_pkg::*;

  item_t   item;
  result_t res;
  logic    seq_ready;
  logic    res_valid;
  logic    load;

  assign item = '{command: command, new_year: new_year, new_month: new_month,
                  new_day: new_day, day_offset: day_offset};
  assign in_ready = seq_ready;
  assign load = res_valid && (!out_valid || out_ready);

  gdo_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && seq_ready),
    .item      (item),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_take  (load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_year <= res.year;
      cur_month <= res.month;
      cur_day <= res.day;
      status <= res.status;
    end
  end

endmodule

// ----- src/gdo_addsub.sv -----
// Shared add and subtract unit for the day count.
module gdo_addsub (
  input  logic [gdo_pkg::DAYS_W-1:0] a,
  input  logic [8:0]                 b,
  input  logic                       sub,
  output logic [gdo_pkg::DAYS_W-1:0] sum
);
  import gdo_pkg::*;

  logic [DAYS_W-1:0] b_ext;

  assign b_ext = {{(DAYS_W-9){1'b0}}, b};
  assign sum = sub ? (a - b_ext) : (a + b_ext);

endmodule

// ----- src/gdo_seq.sv -----
// Sequencer and date registers: validates, rolls years and splits months.
module gdo_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gdo_pkg::item_t  item,
  output logic            ready,
  output logic            res_valid,
  input  logic            res_take,
  output gdo_pkg::result_t res
);
  import gdo_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SPLIT  = 4'd1;
  localparam logic [3:0] S_SETCHK = 4'd2;
  localparam logic [3:0] S_PRE    = 4'd3;
  localparam logic [3:0] S_MSUM   = 4'd4;
  localparam logic [3:0] S_BACK   = 4'd5;
  localparam logic [3:0] S_FWD    = 4'd6;
  localparam logic [3:0] S_MONTH  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state;
  logic [13:0]       year_reg;
  logic [6:0]        cent_reg;
  logic [6:0]        yic_reg;
  logic [3:0]        month_reg;
  logic [4:0]        day_reg;
  logic [1:0]        status;

  logic [6:0]        wc;
  logic [6:0]        wr;
  logic [3:0]        mo;
  logic [DAYS_W-1:0] days;
  logic [13:0]       ny;
  logic [3:0]        nm;
  logic [4:0]        nd;

  logic              leap_cur;
  logic              leap_prev;
  logic [6:0]        pc;
  logic [6:0]        pr;
  logic [6:0]        nc;
  logic [6:0]        nr;
  logic              year_zero;
  logic              year_max;
  logic [8:0]        op;
  logic              op_sub;
  logic [DAYS_W-1:0] sum;
  logic              sum_neg;
  logic [26:0]       prod;
  logic [13:0]       c100;
  logic [13:0]       r_full;
  logic [6:0]        rr;
  logic [4:0]        set_dim;
  logic              set_bad;
  logic [13:0]       year_adv;

  assign leap_cur = is_leap(wc, wr);
  assign year_zero = (wc == 7'd0) && (wr == 7'd0);
  assign year_max = (wc == 7'd99) && (wr == 7'd99);
  assign pc = (wr == 7'd0) ? (wc - 7'd1) : wc;
  assign pr = (wr == 7'd0) ? 7'd99 : (wr - 7'd1);
  assign nc = (wr == 7'd99) ? (wc + 7'd1) : wc;
  assign nr = (wr == 7'd99) ? 7'd0 : (wr + 7'd1);
  assign leap_prev = is_leap(pc, pr);

  always_comb begin
    op = 9'd0;
    op_sub = 1'b0;
    case (state)
      S_PRE: op = {4'd0, day_reg - 5'd1};
      S_MSUM: op = {4'd0, days_in_month(leap_cur, mo)};
      S_BACK: op = days_in_year(leap_prev);
      S_FWD: begin
        op = days_in_year(leap_cur);
        op_sub = 1'b1;
      end
      S_MONTH: begin
        op = {4'd0, days_in_month(leap_cur, mo)};
        op_sub = 1'b1;
      end
      default: op = 9'd0;
    endcase
  end

  gdo_addsub u_addsub (
    .a   (days),
    .b   (op),
    .sub (op_sub),
    .sum (sum)
  );

  assign sum_neg = sum[DAYS_W-1];

  assign prod = 27'(ny) * 27'(RECIP_100);
  assign c100 = 14'(wc) * 14'd100;
  assign r_full = ny - c100;
  assign rr = r_full[6:0];
  assign set_dim = days_in_month(is_leap(wc, rr), nm);
  assign set_bad = (nm == 4'd0) || (nm > 4'd12) || (nd == 5'd0) || (nd > set_dim);
  assign year_adv = c100 + 14'(wr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      year_reg <= 14'd2000;
      cent_reg <= 7'd20;
      yic_reg <= 7'd0;
      month_reg <= 4'd1;
      day_reg <= 5'd1;
      status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ny <= item.new_year;
            nm <= item.new_month;
            nd <= item.new_day;
            wc <= cent_reg;
            wr <= yic_reg;
            mo <= 4'd1;
            days <= {{(DAYS_W-OFFSET_BITS){item.day_offset[OFFSET_BITS-1]}}, item.day_offset};
            status <= ST_OK;
            state <= (item.command == CMD_ADVANCE) ? S_PRE : S_SPLIT;
          end
        end
        S_SPLIT: begin
          wc <= prod[RECIP_SHIFT+6:RECIP_SHIFT];
          state <= S_SETCHK;
        end
        S_SETCHK: begin
          if (ny > MAX_YEAR) begin
            status <= ST_RANGE;
          end else if (set_bad) begin
            status <= ST_INVALID;
          end else begin
            year_reg <= ny;
            cent_reg <= wc;
            yic_reg <= rr;
            month_reg <= nm;
            day_reg <= nd;
          end
          state <= S_DONE;
        end
        S_PRE: begin
          days <= sum;
          state <= S_MSUM;
        end
        S_MSUM: begin
          if (mo < month_reg) begin
            days <= sum;
            mo <= mo + 4'd1;
          end else begin
            state <= S_BACK;
          end
        end
        S_BACK: begin
          if (days[DAYS_W-1]) begin
            if (year_zero) begin
              status <= ST_RANGE;
              state <= S_DONE;
            end else begin
              wc <= pc;
              wr <= pr;
              days <= sum;
            end
          end else begin
            state <= S_FWD;
          end
        end
        S_FWD: begin
          if (!sum_neg) begin
            days <= sum;
            if (year_max) begin
              status <= ST_RANGE;
              state <= S_DONE;
            end else begin
              wc <= nc;
              wr <= nr;
            end
          end else begin
            mo <= 4'd1;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((mo < 4'd12) && !sum_neg) begin
            days <= sum;
            mo <= mo + 4'd1;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          year_reg <= year_adv;
          cent_reg <= wc;
          yic_reg <= wr;
          month_reg <= mo;
          day_reg <= days[4:0] + 5'd1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{year: year_reg, month: month_reg, day: day_reg, status: status};

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("Item started while the sequencer was busy.");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (month_reg >= 4'd1) && (month_reg <= 4'd12))
    else $error("Stored month left 1..12.");

  a_fwd_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD) |-> !days[DAYS_W-1])
    else $error("Forward roll entered with a negative day count.");

  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MONTH) |-> (days < DAYS_W'(366)))
    else $error("Day of year out of range in the month split.");

  a_year_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (year_reg == 14'(cent_reg) * 14'd100 + 14'(yic_reg)))
    else $error("Stored year disagrees with its century split.");

endmodule
